// ----- rtl/hpzt_pkg.sv -----
// Shared types, constants and register map for the head pose zone tracker.
package hpzt_pkg;

    localparam int TIME_BITS  = 32;
    localparam int COUNT_BITS = 16;

    localparam int STAMP_W   = 32;
    localparam int ANGLE_W   = 16;
    localparam int THR_W     = 15;
    localparam int CONF_W    = 32;
    localparam int CNT_OUT_W = 16;
    localparam int ZONE_W    = 3;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;
    localparam int CMP_BITS  = (TIME_BITS > CONF_W) ? TIME_BITS : CONF_W;

    localparam logic [THR_W-1:0]  YAW_ENTER_RST    = THR_W'(1280);
    localparam logic [THR_W-1:0]  YAW_EXIT_RST     = THR_W'(960);
    localparam logic [THR_W-1:0]  PITCH_ENTER_RST  = THR_W'(1280);
    localparam logic [THR_W-1:0]  PITCH_EXIT_RST   = THR_W'(960);
    localparam logic [CONF_W-1:0] CONFIRM_TIME_RST = CONF_W'(300000);

    typedef enum logic [ZONE_W-1:0] {
        ZONE_UNKNOWN = 3'd0,
        ZONE_NEUTRAL = 3'd1,
        ZONE_LEFT    = 3'd2,
        ZONE_RIGHT   = 3'd3,
        ZONE_UP      = 3'd4,
        ZONE_DOWN    = 3'd5
    } t_zone;

    typedef enum logic [IDX_W-1:0] {
        REG_YAW_ENTER    = 3'd0,
        REG_YAW_EXIT     = 3'd1,
        REG_PITCH_ENTER  = 3'd2,
        REG_PITCH_EXIT   = 3'd3,
        REG_CONFIRM_TIME = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [THR_W-1:0]  yaw_enter;
        logic [THR_W-1:0]  yaw_exit;
        logic [THR_W-1:0]  pitch_enter;
        logic [THR_W-1:0]  pitch_exit;
        logic [CONF_W-1:0] confirm_time;
    } t_cfg;

    typedef struct packed {
        logic [STAMP_W-1:0]        stamp;
        logic                      sample_usable;
        logic                      yaw_present;
        logic signed [ANGLE_W-1:0] yaw_angle;
        logic                      pitch_present;
        logic signed [ANGLE_W-1:0] pitch_angle;
    } t_sample;

    typedef struct packed {
        t_zone                 zone;
        logic                  move_event;
        logic [COUNT_BITS-1:0] left_moves;
        logic [COUNT_BITS-1:0] right_moves;
        logic [COUNT_BITS-1:0] up_moves;
        logic [COUNT_BITS-1:0] down_moves;
    } t_result;

endpackage

// ----- rtl/hpzt_cfg.sv -----
// Configuration register file with APB-style access and validity check.
module hpzt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpzt_pkg::ADDR_W-1:0]   paddr,
    input  logic [hpzt_pkg::DATA_W-1:0]   pwdata,
    output logic [hpzt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output hpzt_pkg::t_cfg                o_cfg,
    output logic                          o_cfg_ok
);

    hpzt_pkg::t_cfg                 r_cfg;
    logic                           wr_en;
    logic [hpzt_pkg::IDX_W-1:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[hpzt_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.yaw_enter    <= hpzt_pkg::YAW_ENTER_RST;
            r_cfg.yaw_exit     <= hpzt_pkg::YAW_EXIT_RST;
            r_cfg.pitch_enter  <= hpzt_pkg::PITCH_ENTER_RST;
            r_cfg.pitch_exit   <= hpzt_pkg::PITCH_EXIT_RST;
            r_cfg.confirm_time <= hpzt_pkg::CONFIRM_TIME_RST;
        end else if (wr_en) begin
            unique case (idx)
                hpzt_pkg::REG_YAW_ENTER:    r_cfg.yaw_enter    <= pwdata[hpzt_pkg::THR_W-1:0];
                hpzt_pkg::REG_YAW_EXIT:     r_cfg.yaw_exit     <= pwdata[hpzt_pkg::THR_W-1:0];
                hpzt_pkg::REG_PITCH_ENTER:  r_cfg.pitch_enter  <= pwdata[hpzt_pkg::THR_W-1:0];
                hpzt_pkg::REG_PITCH_EXIT:   r_cfg.pitch_exit   <= pwdata[hpzt_pkg::THR_W-1:0];
                hpzt_pkg::REG_CONFIRM_TIME: r_cfg.confirm_time <= pwdata[hpzt_pkg::CONF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            hpzt_pkg::REG_YAW_ENTER:    prdata = hpzt_pkg::DATA_W'(r_cfg.yaw_enter);
            hpzt_pkg::REG_YAW_EXIT:     prdata = hpzt_pkg::DATA_W'(r_cfg.yaw_exit);
            hpzt_pkg::REG_PITCH_ENTER:  prdata = hpzt_pkg::DATA_W'(r_cfg.pitch_enter);
            hpzt_pkg::REG_PITCH_EXIT:   prdata = hpzt_pkg::DATA_W'(r_cfg.pitch_exit);
            hpzt_pkg::REG_CONFIRM_TIME: prdata = hpzt_pkg::DATA_W'(r_cfg.confirm_time);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg    = r_cfg;
    assign o_cfg_ok = (r_cfg.yaw_exit < r_cfg.yaw_enter)
                   && (r_cfg.pitch_exit < r_cfg.pitch_enter)
                   && (r_cfg.confirm_time != '0);

endmodule

// ----- rtl/hpzt_core.sv -----
// Tracker state and per-sample zone classification, confirmation and counting.
module hpzt_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  hpzt_pkg::t_sample i_smp,
    input  hpzt_pkg::t_cfg    i_cfg,
    input  logic              i_cfg_ok,
    output hpzt_pkg::t_result o_res
);

    localparam int TB = hpzt_pkg::TIME_BITS;
    localparam int CB = hpzt_pkg::COUNT_BITS;
    localparam int AW = hpzt_pkg::ANGLE_W;
    localparam int CW = hpzt_pkg::CMP_BITS;

    logic                r_seen,       n_seen;
    logic [TB-1:0]       r_last,       n_last;
    hpzt_pkg::t_zone     r_cur,        n_cur;
    hpzt_pkg::t_zone     r_pend_zone,  n_pend_zone;
    logic                r_pend_valid, n_pend_valid;
    logic [TB-1:0]       r_pend_start, n_pend_start;
    logic                r_rearm,      n_rearm;
    logic [CB-1:0]       r_left,  n_left;
    logic [CB-1:0]       r_right, n_right;
    logic [CB-1:0]       r_up,    n_up;
    logic [CB-1:0]       r_down,  n_down;

    logic [TB-1:0]       stamp;
    logic [TB-1:0]       elapsed;
    logic                usable;
    logic                reject;
    logic [AW-1:0]       abs_yaw;
    logic [AW-1:0]       abs_pitch;
    logic [AW-1:0]       yaw_lim;
    logic [AW-1:0]       pitch_lim;
    hpzt_pkg::t_zone     raw;
    logic                ev;

    assign stamp  = TB'(i_smp.stamp);
    assign usable = i_smp.sample_usable && i_smp.yaw_present && i_smp.pitch_present;
    assign reject = !i_cfg_ok || (r_seen && (stamp <= r_last));

    // most negative angle wraps to 2^(AW-1), above every threshold
    assign abs_yaw   = i_smp.yaw_angle[AW-1]   ? AW'(-i_smp.yaw_angle)   : AW'(i_smp.yaw_angle);
    assign abs_pitch = i_smp.pitch_angle[AW-1] ? AW'(-i_smp.pitch_angle) : AW'(i_smp.pitch_angle);

    assign yaw_lim   = (r_cur == hpzt_pkg::ZONE_LEFT || r_cur == hpzt_pkg::ZONE_RIGHT)
                     ? AW'(i_cfg.yaw_exit) : AW'(i_cfg.yaw_enter);
    assign pitch_lim = (r_cur == hpzt_pkg::ZONE_UP || r_cur == hpzt_pkg::ZONE_DOWN)
                     ? AW'(i_cfg.pitch_exit) : AW'(i_cfg.pitch_enter);

    always_comb begin
        if (abs_yaw >= yaw_lim) begin
            raw = i_smp.yaw_angle[AW-1] ? hpzt_pkg::ZONE_LEFT : hpzt_pkg::ZONE_RIGHT;
        end else if (abs_pitch >= pitch_lim) begin
            raw = i_smp.pitch_angle[AW-1] ? hpzt_pkg::ZONE_UP : hpzt_pkg::ZONE_DOWN;
        end else begin
            raw = hpzt_pkg::ZONE_NEUTRAL;
        end
    end

    always_comb begin
        n_seen       = r_seen;
        n_last       = r_last;
        n_cur        = r_cur;
        n_pend_zone  = r_pend_zone;
        n_pend_valid = r_pend_valid;
        n_pend_start = r_pend_start;
        n_rearm      = r_rearm;
        n_left       = r_left;
        n_right      = r_right;
        n_up         = r_up;
        n_down       = r_down;
        ev           = 1'b0;
        elapsed      = '0;
        if (!reject) begin
            n_seen = 1'b1;
            n_last = stamp;
            if (!usable) begin
                n_cur        = hpzt_pkg::ZONE_UNKNOWN;
                n_pend_valid = 1'b0;
            end else begin
                if (raw != r_pend_zone) begin
                    n_pend_zone  = raw;
                    n_pend_valid = 1'b1;
                    n_pend_start = stamp;
                end
                elapsed = stamp - n_pend_start;
                if (n_pend_valid && (CW'(elapsed) >= CW'(i_cfg.confirm_time))
                        && (r_cur != n_pend_zone)) begin
                    n_cur = n_pend_zone;
                    if (n_pend_zone == hpzt_pkg::ZONE_NEUTRAL) begin
                        n_rearm = 1'b1;
                    end else if (r_rearm) begin
                        n_rearm = 1'b0;
                        ev      = 1'b1;
                        case (n_pend_zone)
                            hpzt_pkg::ZONE_LEFT:  if (r_left  != '1) n_left  = r_left  + 1'b1;
                            hpzt_pkg::ZONE_RIGHT: if (r_right != '1) n_right = r_right + 1'b1;
                            hpzt_pkg::ZONE_UP:    if (r_up    != '1) n_up    = r_up    + 1'b1;
                            hpzt_pkg::ZONE_DOWN:  if (r_down  != '1) n_down  = r_down  + 1'b1;
                            default: ;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_last       <= '0;
            r_cur        <= hpzt_pkg::ZONE_UNKNOWN;
            r_pend_zone  <= hpzt_pkg::ZONE_UNKNOWN;
            r_pend_valid <= 1'b0;
            r_pend_start <= '0;
            r_rearm      <= 1'b1;
            r_left       <= '0;
            r_right      <= '0;
            r_up         <= '0;
            r_down       <= '0;
        end else if (i_fire) begin
            r_seen       <= n_seen;
            r_last       <= n_last;
            r_cur        <= n_cur;
            r_pend_zone  <= n_pend_zone;
            r_pend_valid <= n_pend_valid;
            r_pend_start <= n_pend_start;
            r_rearm      <= n_rearm;
            r_left       <= n_left;
            r_right      <= n_right;
            r_up         <= n_up;
            r_down       <= n_down;
        end
    end

    assign o_res.zone        = reject ? hpzt_pkg::ZONE_UNKNOWN : n_cur;
    assign o_res.move_event  = ev;
    assign o_res.left_moves  = n_left;
    assign o_res.right_moves = n_right;
    assign o_res.up_moves    = n_up;
    assign o_res.down_moves  = n_down;

endmodule

// ----- rtl/head_pose_zone_tracker.sv -----
// Head pose zone tracker top level: request registers, core and result register.
//
// Takes one pose sample request per clock while o_stall is low and returns one result
// per sample, in order. A request is captured in an input register, processed by the
// tracker core (which updates the zone, confirmation and counter state), and the
// result lands in an output register that drives o_valid; throughput is one request
// per cycle as long as o_valid is not held by i_stall. The output register frees the
// input side while a result waits.
// Registers (APB, byte address 4*i): 0 yaw_enter, 1 yaw_exit, 2 pitch_enter,
// 3 pitch_exit, 4 confirm_time. Write registers only while no request is in flight.
// A sample is rejected (zone unknown, no state change) when exit >= enter on either
// axis, confirm_time is zero, or the stamp does not increase.
module head_pose_zone_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [hpzt_pkg::STAMP_W-1:0]        i_stamp,
    input  logic                                i_sample_usable,
    input  logic                                i_yaw_present,
    input  logic signed [hpzt_pkg::ANGLE_W-1:0] i_yaw_angle,
    input  logic                                i_pitch_present,
    input  logic signed [hpzt_pkg::ANGLE_W-1:0] i_pitch_angle,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [hpzt_pkg::ZONE_W-1:0]         o_zone,
    output logic                                o_move_event,
    output logic [hpzt_pkg::CNT_OUT_W-1:0]      o_left_moves,
    output logic [hpzt_pkg::CNT_OUT_W-1:0]      o_right_moves,
    output logic [hpzt_pkg::CNT_OUT_W-1:0]      o_up_moves,
    output logic [hpzt_pkg::CNT_OUT_W-1:0]      o_down_moves,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hpzt_pkg::ADDR_W-1:0]         paddr,
    input  logic [hpzt_pkg::DATA_W-1:0]         pwdata,
    output logic [hpzt_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    hpzt_pkg::t_cfg    cfg;
    logic              cfg_ok;
    logic              r_in_valid;
    hpzt_pkg::t_sample r_in;
    logic              r_out_valid;
    hpzt_pkg::t_result r_out;
    hpzt_pkg::t_result core_res;
    logic              adv;
    logic              take;

    hpzt_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_cfg_ok (cfg_ok)
    );

    hpzt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (adv),
        .i_smp    (r_in),
        .i_cfg    (cfg),
        .i_cfg_ok (cfg_ok),
        .o_res    (core_res)
    );

    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in.stamp         <= i_stamp;
            r_in.sample_usable <= i_sample_usable;
            r_in.yaw_present   <= i_yaw_present;
            r_in.yaw_angle     <= i_yaw_angle;
            r_in.pitch_present <= i_pitch_present;
            r_in.pitch_angle   <= i_pitch_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_zone        = r_out.zone;
    assign o_move_event  = r_out.move_event;
    assign o_left_moves  = hpzt_pkg::CNT_OUT_W'(r_out.left_moves);
    assign o_right_moves = hpzt_pkg::CNT_OUT_W'(r_out.right_moves);
    assign o_up_moves    = hpzt_pkg::CNT_OUT_W'(r_out.up_moves);
    assign o_down_moves  = hpzt_pkg::CNT_OUT_W'(r_out.down_moves);

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_valid)
        else $error("processed request did not produce a result");

    a_bad_cfg_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !cfg_ok |=> (o_zone == hpzt_pkg::ZONE_UNKNOWN) && !o_move_event)
        else $error("request under invalid configuration not rejected");

    a_event_zone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_move_event |->
            (o_zone == hpzt_pkg::ZONE_LEFT) || (o_zone == hpzt_pkg::ZONE_RIGHT)
            || (o_zone == hpzt_pkg::ZONE_UP) || (o_zone == hpzt_pkg::ZONE_DOWN))
        else $error("move event outside a movement zone");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with room in the pipeline");

endmodule
